// File: src/ggnc_pkg.sv
`default_nettype none
package ggnc_pkg;
	localparam int GRAD_W    = 16;
	localparam int THR_W     = 24;
	localparam int SUM_W     = 37;
	localparam int NORM_W    = 19;
	localparam int PROD_W    = GRAD_W + THR_W;
	localparam int QUOT_W    = 16;
	localparam int MAX_GROUP_DEF = 64;
	localparam logic [THR_W-1:0] THR_RESET = 24'd4096;
endpackage
`default_nettype wire

// File: src/ggnc_mem.sv
`default_nettype none
module ggnc_mem
	import ggnc_pkg::*;
#(
	parameter int DEPTH = MAX_GROUP_DEF,
	parameter int AW = 6
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [GRAD_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [GRAD_W-1:0] rdata_q
);
	logic [GRAD_W-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// File: src/ggnc_sqrt.sv
`default_nettype none
module ggnc_sqrt
	import ggnc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [SUM_W-1:0]  value,
	output logic                   done_q,
	output logic      [NORM_W-1:0] root
);
	logic [SUM_W-1:0] v_q;
	logic [SUM_W-1:0] res_q;
	logic [SUM_W-1:0] bit_q;
	logic             busy_q;
	logic [SUM_W:0]   trial;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign root  = res_q[NORM_W-1:0];

	// digit-by-digit root, two radicand bits per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (bit_q[1:0] != 2'b00) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			res_q <= '0;
			bit_q <= {1'b1, {(SUM_W-1){1'b0}}};
		end else if (busy_q) begin
			if ({1'b0, v_q} >= trial) begin
				v_q   <= v_q - trial[SUM_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule
`default_nettype wire

// File: src/ggnc_div.sv
`default_nettype none
module ggnc_div
	import ggnc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [PROD_W-1:0] dividend,
	input  wire logic [NORM_W-1:0] divisor,
	output logic                   done_q,
	output logic      [QUOT_W-1:0] quot_q
);
	logic [NORM_W-1:0] rem_q;
	logic [QUOT_W-1:0] low_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic [NORM_W:0]   trial;

	// quotient fits 16 bits, so the high part is already below the divisor
	assign trial = {rem_q, low_q[QUOT_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(QUOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend[NORM_W+QUOT_W-1:QUOT_W];
			low_q  <= dividend[QUOT_W-1:0];
			quot_q <= '0;
		end else if (busy_q) begin
			low_q <= low_q << 1;
			if (trial >= {1'b0, divisor}) begin
				rem_q  <= NORM_W'(trial - {1'b0, divisor});
				quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= trial[NORM_W-1:0];
				quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// File: src/group_gradient_norm_clipper.sv
// Input: one value per cycle while a group is collected; the close passes through ST_FIN and ST_CMP.
// Clip check, then a square root for a clipped group only (19-step root unit).
// Output: values go one at a time through ST_RD, ST_DATA and ST_OUT, a clipped one also the 16-step divider.
// Rate is set by the single buffer read port, the shared iterative divider and output back-pressure.
// Reset (arst_n low, asynchronous) empties the group and sets the threshold to 1.0.
`default_nettype none
module group_gradient_norm_clipper
	import ggnc_pkg::*;
#(
	parameter int MAX_GROUP = MAX_GROUP_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // grad_in
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [15:0] m_axis_tdata,   // grad_out
	output logic             m_axis_tuser,   // clipped
	output logic             m_axis_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [23:0] cfg_data        // clip_threshold
);
	localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int CW = $clog2(MAX_GROUP + 1);

	typedef enum logic [3:0] {
		ST_COLLECT, ST_FIN, ST_CMP, ST_SQRT, ST_RD, ST_DATA,
		ST_DSTART, ST_DWAIT, ST_OUT
	} state_t;

	state_t              state_q;
	logic [THR_W-1:0]    thr_q;
	logic [2*THR_W-1:0]  thr_sq_q;
	logic [SUM_W-1:0]    sum_q;
	logic [31:0]         sq_s1;
	logic                sqv_s1;
	logic [CW-1:0]       fill_q;
	logic [CW-1:0]       idx_q;
	logic                clip_q;
	logic [NORM_W-1:0]   norm_q;
	logic [PROD_W-1:0]   prod_q;
	logic                neg_q;
	logic [GRAD_W-1:0]   result_q;

	logic                accept;
	logic                closing;
	logic [GRAD_W-1:0]   mag_in;
	logic [GRAD_W-1:0]   rdata;
	logic [GRAD_W-1:0]   mag_rd;
	logic                sqrt_start;
	logic                sqrt_done;
	logic [NORM_W-1:0]   sqrt_root;
	logic                div_start;
	logic                div_done;
	logic [QUOT_W-1:0]   div_quot;
	logic                out_free;
	logic                is_last;

	assign s_axis_tready = (state_q == ST_COLLECT);
	assign cfg_ready     = 1'b1;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign closing       = s_axis_tlast || (fill_q == CW'(MAX_GROUP - 1));
	assign mag_in        = s_axis_tdata[15] ? (~s_axis_tdata + 16'd1) : s_axis_tdata;
	assign mag_rd        = rdata[15] ? (~rdata + 16'd1) : rdata;
	// full-width compare of the sum against the squared threshold
	assign sqrt_start    = (state_q == ST_CMP) &&
		({(2*THR_W-SUM_W)'(0), sum_q} > thr_sq_q);
	assign div_start     = (state_q == ST_DSTART);
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign is_last       = (idx_q + CW'(1) == fill_q);

	ggnc_mem #(.DEPTH(MAX_GROUP), .AW(AW)) u_mem (
		.clk     (clk),
		.we      (accept),
		.waddr   (fill_q[AW-1:0]),
		.wdata   (s_axis_tdata),
		.re      (state_q == ST_RD),
		.raddr   (idx_q[AW-1:0]),
		.rdata_q (rdata)
	);

	ggnc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (sum_q),
		.done_q (sqrt_done),
		.root   (sqrt_root)
	);

	ggnc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (norm_q),
		.done_q   (div_done),
		.quot_q   (div_quot)
	);

	// threshold register and its square
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		thr_sq_q <= thr_q * thr_q;
	end

	// payload datapath
	always_ff @(posedge clk) begin
		sq_s1 <= mag_in * mag_in;
		if (sqrt_done) begin
			norm_q <= (sqrt_root == '0) ? NORM_W'(1) : sqrt_root;
		end
		if (state_q == ST_DATA) begin
			prod_q   <= mag_rd * thr_q;
			neg_q    <= rdata[15];
			result_q <= rdata;
		end
		if (div_done) begin
			result_q <= neg_q ? (~div_quot + 16'd1) : div_quot;
		end
	end

	// control sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_COLLECT;
			sum_q         <= '0;
			sqv_s1        <= 1'b0;
			fill_q        <= '0;
			idx_q         <= '0;
			clip_q        <= 1'b0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= 1'b0;
			m_axis_tlast  <= 1'b0;
		end else begin
			sqv_s1 <= accept;
			if (sqv_s1) begin
				sum_q <= sum_q + SUM_W'(sq_s1);
			end
			// ST_OUT loads the next result itself
			if (m_axis_tready && (state_q != ST_OUT)) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				ST_COLLECT: begin
					if (accept) begin
						fill_q <= fill_q + CW'(1);
						if (closing) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					idx_q  <= '0;
					clip_q <= sqrt_start;
					state_q <= sqrt_start ? ST_SQRT : ST_RD;
				end
				ST_SQRT: begin
					if (sqrt_done) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_DATA;
				end
				ST_DATA: begin
					state_q <= clip_q ? ST_DSTART : ST_OUT;
				end
				ST_DSTART: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= result_q;
						m_axis_tuser  <= clip_q;
						m_axis_tlast  <= is_last;
						idx_q         <= idx_q + CW'(1);
						if (is_last) begin
							fill_q  <= '0;
							sum_q   <= '0;
							state_q <= ST_COLLECT;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`default_nettype none
module testbench;
	import ggnc_pkg::*;

	localparam int GROUP_CAP = 64;

	// one gradient sample plus its group mark
	typedef struct packed {
		logic [15:0] grad;
		logic        last;
	} grad_req_t;

	// one clipped or unchanged result
	typedef struct packed {
		logic [15:0] grad;
		logic        clipped;
		logic        last;
	} grad_rsp_t;

	// directed rows: a threshold write, or a request with an optional typed-in result
	typedef enum logic [1:0] {ROW_THR, ROW_REQ, ROW_REQ_EXP} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [23:0] thr;
		grad_req_t   req;
		grad_rsp_t   rsp;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [23:0] cfg_data;

	// predictor state
	logic [15:0] grp_vals[GROUP_CAP];
	int unsigned grp_fill;
	logic [36:0] grp_sq_sum;
	logic [23:0] clip_thr;

	grad_rsp_t   clip_results[$];
	grad_rsp_t   typed_results[$];
	logic        typed_valid[$];
	int          fail_count;
	bit          idle_free;

	stim_row_t   dir_rows[$];

	group_gradient_norm_clipper dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),   // grad_in
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),   // grad_out
		.m_axis_tuser (m_axis_tuser),   // clipped
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)        // clip_threshold
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// floor square root, bit by bit
	function automatic logic [63:0] floor_root(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// absorb one request; on group close push its whole burst of results
	task automatic clip_predict(input grad_req_t r);
		logic signed [15:0] gv;
		logic [63:0]        mag;
		logic [63:0]        norm;
		logic [63:0]        thr;
		logic [63:0]        q;
		logic               clip;
		grad_rsp_t          o;
		gv = r.grad;
		mag = (gv < 0) ? 64'(-64'(gv)) : 64'(gv);
		if (grp_fill >= GROUP_CAP)
			grp_fill = 0;
		grp_vals[grp_fill] = r.grad;
		grp_fill++;
		grp_sq_sum = 37'(grp_sq_sum + mag * mag);
		if (!r.last && grp_fill < GROUP_CAP)
			return;
		thr = 64'(clip_thr);
		clip = 64'(grp_sq_sum) > thr * thr;
		norm = 1;
		if (clip) begin
			norm = floor_root(64'(grp_sq_sum));
			if (norm == 0)
				norm = 1;
		end
		for (int i = 0; i < grp_fill; i++) begin
			gv = grp_vals[i];
			o.grad = gv;
			if (clip) begin
				mag = (gv < 0) ? 64'(-64'(gv)) : 64'(gv);
				q = (mag * thr) / norm;
				o.grad = (gv < 0) ? 16'(-q) : 16'(q);
			end
			o.clipped = clip;
			o.last = (i + 1 == grp_fill);
			clip_results.push_back(o);
		end
		grp_fill = 0;
		grp_sq_sum = 0;
	endtask

	task automatic idle_gap(input int pct);
		while (!idle_free && $urandom_range(99) < pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// one request, handshake-paced; valid stays up for a following request
	task automatic send_req(input grad_req_t r);
		idle_gap(21);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= r.grad;
		s_axis_tlast  <= r.last;
		do @(posedge clk); while (!s_axis_tready);
		clip_predict(r);
	endtask

	task automatic drain_wait;
		s_axis_tvalid <= 1'b0;
		while (clip_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_thr(input logic [23:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		clip_thr = v;
	endtask

	function automatic stim_row_t mk_row(input row_kind_t k, input logic [23:0] t,
			input logic [15:0] g, input logic l, input logic [15:0] eg,
			input logic ec, input logic el);
		stim_row_t s;
		s.kind = k;
		s.thr = t;
		s.req = '{grad: g, last: l};
		s.rsp = '{grad: eg, clipped: ec, last: el};
		return s;
	endfunction

	// result checker with random backpressure
	always @(posedge clk) begin
		grad_rsp_t e;
		grad_rsp_t a;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				a = '{grad: m_axis_tdata, clipped: m_axis_tuser, last: m_axis_tlast};
				if (clip_results.size() == 0) begin
					$display("%0t: unexpected result %h", $time, a);
					fail_count++;
				end else begin
					e = clip_results.pop_front();
					if (typed_valid.size() != 0 && typed_valid.pop_front()) begin
						if (typed_results.pop_front() !== e) begin
							$display("%0t: table row disagrees with predictor %h", $time, e);
							fail_count++;
						end
					end
					if (a.grad !== e.grad)
						$display("%0t: grad expected %h actual %h", $time, e.grad, a.grad);
					if (a.clipped !== e.clipped)
						$display("%0t: clipped expected %b actual %b", $time, e.clipped,
							a.clipped);
					if (a.last !== e.last)
						$display("%0t: last expected %b actual %b", $time, e.last, a.last);
					if (a !== e)
						fail_count++;
				end
			end
			m_axis_tready <= idle_free || ($urandom_range(99) >= 21);
		end
	end

	// run limit
	initial begin
		#20000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		grad_req_t r;
		int        glen;
		int        mode;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		grp_fill      = 0;
		grp_sq_sum    = '0;
		clip_thr      = THR_RESET;
		fail_count    = 0;
		idle_free     = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: reset threshold 1.0, extremes, zero, maximum and unit thresholds
		dir_rows.push_back(mk_row(ROW_REQ_EXP, 0, 16'h0800, 1, 16'h0800, 0, 1));
		dir_rows.push_back(mk_row(ROW_REQ_EXP, 0, 16'h1000, 1, 16'h1000, 0, 1));
		dir_rows.push_back(mk_row(ROW_REQ_EXP, 0, 16'h2000, 1, 16'h1000, 1, 1));
		dir_rows.push_back(mk_row(ROW_REQ_EXP, 0, 16'hE000, 1, 16'hF000, 1, 1));
		dir_rows.push_back(mk_row(ROW_REQ, 0, 16'h7FFF, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_REQ, 0, 16'h8000, 1, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_THR, 24'd0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_REQ_EXP, 0, 16'h0000, 1, 16'h0000, 0, 1));
		dir_rows.push_back(mk_row(ROW_REQ_EXP, 0, 16'h8000, 1, 16'h0000, 1, 1));
		dir_rows.push_back(mk_row(ROW_REQ_EXP, 0, 16'h0001, 1, 16'h0000, 1, 1));
		dir_rows.push_back(mk_row(ROW_THR, 24'hFFFFFF, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_REQ_EXP, 0, 16'h8000, 1, 16'h8000, 0, 1));
		dir_rows.push_back(mk_row(ROW_REQ, 0, 16'h7FFF, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_REQ, 0, 16'h5555, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_REQ, 0, 16'hAAAA, 1, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_THR, 24'd1, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_REQ, 0, 16'h7FFF, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_REQ, 0, 16'h8001, 1, 0, 0, 0));
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_THR) begin
				drain_wait();
				write_thr(dir_rows[i].thr);
			end else begin
				typed_valid.push_back(dir_rows[i].kind == ROW_REQ_EXP);
				if (dir_rows[i].kind == ROW_REQ_EXP)
					typed_results.push_back(dir_rows[i].rsp);
				send_req(dir_rows[i].req);
			end
		end
		// typed rows only cover the first results; later ones go by predictor alone
		drain_wait();
		typed_valid.delete();

		// full group of 64 without a last mark closes by itself
		write_thr(24'd20000);
		for (int i = 0; i < GROUP_CAP; i++)
			send_req('{grad: 16'($urandom), last: 1'b0});
		drain_wait();

		// random groups, threshold changed between phases
		for (int ph = 0; ph < 8; ph++) begin
			drain_wait();
			case (ph)
				0: write_thr(24'd0);
				1: write_thr(24'hFFFFFF);
				2: write_thr(24'd4096);
				default: write_thr(24'($urandom_range(40000)));
			endcase
			idle_free = (ph == 5);
			for (int g = 0; g < 5; g++) begin
				mode = $urandom_range(9);
				glen = (mode == 0) ? GROUP_CAP : $urandom_range(1, 8);
				for (int i = 0; i < glen; i++) begin
					r.grad = (mode < 3) ? 16'($urandom) : 16'($signed($urandom_range(0, 8191))
						- 4096);
					r.last = (i == glen - 1) && (glen != GROUP_CAP || $urandom_range(1));
					send_req(r);
				end
			end
		end
		idle_free = 1'b0;
		drain_wait();

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
